[sv/assert_macros.svh]
// Assertion macros shared by the cache lookup RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SACL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/sacl_pkg.sv]
// Shared constants, types and register codes for the LFU cache tag lookup.
// No dependencies; used by the interfaces, front end, back end and top level.
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W      = 32;
  localparam int SET_BITS    = 6;
  localparam int WAY_BITS    = 2;
  localparam int COUNT_WIDTH = 16;

  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int NUM_WAYS = 1 << WAY_BITS;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W    = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int TAG_W    = ADDR_W - SET_BITS;
  localparam int ROW_W    = NUM_WAYS * (TAG_W + COUNT_WIDTH);

  localparam int OFFS_W     = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET_BITS = CFG_IDX_W'(1);

  localparam logic              OP_WRITE   = 1'b1;
  localparam logic              WA_RESET   = 1'b1;
  localparam logic [OFFS_W-1:0] OFFS_RESET = OFFS_W'(6);

  typedef logic [SET_W-1:0]       set_t;
  typedef logic [WAY_W-1:0]       way_idx_t;
  typedef logic [TAG_W-1:0]       tag_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  localparam cnt_t COUNT_MAX = '1;

  typedef struct packed {
    tag_t tag;
    cnt_t cnt;
  } way_t;

  typedef way_t [NUM_WAYS-1:0] row_t;

  typedef struct packed {
    set_t set;
    tag_t tag;
    logic no_alloc;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_out_t;

  typedef enum logic [1:0] {
    BK_ISSUE  = 2'b01,
    BK_LOOKUP = 2'b10
  } bk_state_t;

endpackage

`default_nettype wire

[sv/sacl_if.sv]
// Valid/ready channel interfaces: access input, result output, config write.
// Depends on sacl_pkg.
`default_nettype none

interface sacl_in_if;
  import sacl_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;
  modport source (output valid, op, address, input ready);
  modport sink   (input valid, op, address, output ready);
endinterface

interface sacl_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic filled;
  modport source (output valid, hit, filled, input ready);
  modport sink   (input valid, hit, filled, output ready);
endinterface

interface sacl_cfg_if;
  import sacl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/sacl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sacl_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/sacl_front.sv]
// Front end: config registers, address split into set/tag, no-allocate
// classification and a two-entry request queue. Depends on sacl_pkg, sacl_if.
`default_nettype none

module sacl_front (
  input  logic             clk,
  input  logic             rst_n,
  sacl_in_if.sink          in_ch,
  sacl_cfg_if.sink         cfg_ch,
  output sacl_pkg::q_out_t q_out,
  input  logic             q_ready
);
  import sacl_pkg::*;

  logic              wr_alloc_r;
  logic [OFFS_W-1:0] offs_r;

  req_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r,  cnt_nxt;

  logic [ADDR_W-1:0] shifted;
  req_t              req_in;
  logic              push, pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_alloc_r <= WA_RESET;
      offs_r     <= OFFS_RESET;
    end else if (cfg_ch.valid) begin
      priority if (cfg_ch.index == REG_WRITE_ALLOCATE) begin
        wr_alloc_r <= cfg_ch.data[0];
      end else if (cfg_ch.index == REG_BLOCK_OFFSET_BITS) begin
        offs_r <= cfg_ch.data[OFFS_W-1:0];
      end
    end
  end

  always_comb begin
    shifted         = in_ch.address >> offs_r;
    req_in.set      = SET_W'(shifted & ADDR_W'(NUM_SETS - 1));
    req_in.tag      = TAG_W'(shifted >> SET_BITS);
    req_in.no_alloc = (in_ch.op == OP_WRITE) && !wr_alloc_r;
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_out.valid = (cnt_r != '0);
  assign q_out.req   = q_mem_r[rptr_r];
  assign pop         = q_out.valid && q_ready;

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= req_in;
    end
  end

endmodule

`default_nettype wire

[sv/sacl_back.sv]
// Back end: set row read, tag compare, LFU victim pick, row write-back,
// valid bits and result register. Depends on sacl_pkg, sacl_if, sacl_ram.
`default_nettype none

module sacl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sacl_pkg::q_out_t q_out,
  output logic             q_ready,
  sacl_out_if.source       out_ch
);
  import sacl_pkg::*;

  bk_state_t state_r, state_nxt;
  req_t      cur_r;
  logic [NUM_SETS-1:0][NUM_WAYS-1:0] vld_r;

  logic out_v_r, hit_r, filled_r;

  logic [ROW_W-1:0] rd_data;
  row_t     rd_row, wr_row;
  logic     pop, fire, out_free, wr_en;
  logic     [NUM_WAYS-1:0] way_vld, way_hit;
  cnt_t     cnt_eff [NUM_WAYS];
  logic     hit_any;
  way_idx_t hit_way, victim;
  cnt_t     vcnt;

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_r.set),
    .wr_data (wr_row),
    .rd_en   (pop),
    .rd_addr (q_out.req.set),
    .rd_data (rd_data)
  );

  assign q_ready  = (state_r == BK_ISSUE);
  assign pop      = q_out.valid && q_ready;
  assign out_free = !out_v_r || out_ch.ready;
  assign fire     = (state_r == BK_LOOKUP) && out_free;
  assign rd_row   = row_t'(rd_data);
  assign way_vld  = vld_r[cur_r.set];

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_hit[w] = way_vld[w] && (rd_row[w].tag == cur_r.tag);
      cnt_eff[w] = way_vld[w] ? rd_row[w].cnt : '0;
      if (!hit_any && way_hit[w]) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    victim = '0;
    vcnt   = cnt_eff[0];
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (cnt_eff[w] < vcnt) begin
        victim = WAY_W'(w);
        vcnt   = cnt_eff[w];
      end
    end
  end

  always_comb begin
    wr_row = rd_row;
    if (hit_any) begin
      if (rd_row[hit_way].cnt != COUNT_MAX) begin
        wr_row[hit_way].cnt = rd_row[hit_way].cnt + cnt_t'(1);
      end
    end else begin
      wr_row[victim].tag = cur_r.tag;
      wr_row[victim].cnt = cnt_t'(1);
    end
  end

  assign wr_en = fire && (hit_any || !cur_r.no_alloc);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_ISSUE:  if (pop)  state_nxt = BK_LOOKUP;
      BK_LOOKUP: if (fire) state_nxt = BK_ISSUE;
      default:             state_nxt = BK_ISSUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_ISSUE;
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en && !hit_any) begin
        vld_r[cur_r.set][victim] <= 1'b1;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_out.req;
    end
    if (fire) begin
      hit_r    <= hit_any;
      filled_r <= !hit_any && !cur_r.no_alloc;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.hit    = hit_r;
  assign out_ch.filled = filled_r;

endmodule

`default_nettype wire

[sv/set_assoc_cache_tag_lookup_lfu_unit.sv]
// Path: an accepted access passes the request queue, the set-row read in the issue
// state and the lookup state, which waits while the result register is full; each
// set row is read, then written back through the single set-row RAM port pair before
// the next access is looked up. Reset: synchronous; clears valid bits, queue and
// control state, no clearing pass; write_allocate resets to 1, block_offset_bits to 6.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_tag_lookup_lfu_unit (
  input  logic        clk,
  input  logic        rst_n,
  sacl_in_if.sink     in_ch,
  sacl_out_if.source  out_ch,
  sacl_cfg_if.sink    cfg_ch
);
  import sacl_pkg::*;

  q_out_t q_out;
  logic   q_ready;

  sacl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_out   (q_out),
    .q_ready (q_ready)
  );

  sacl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_out   (q_out),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

  `SACL_ASSERT_NEXT(a_pop_then_lookup, q_out.valid && q_ready, !q_ready)
  `SACL_ASSERT_NOW(a_hit_never_fills, out_ch.valid && out_ch.hit, !out_ch.filled)
  `SACL_ASSERT_NOW(a_result_from_lookup, $rose(out_ch.valid), $past(!q_ready))

endmodule

`default_nettype wire
